### rtl/frm_pkg.sv
// Frame rate meter package: widths, window size, register indexes and
// the types shared between the register block, divider and top level.
// No dependencies.
package frm_pkg;

  localparam int WINDOW    = 128;
  localparam int PTR_W     = $clog2(WINDOW);
  localparam int ELAPSED_W = 32;
  localparam int STEP_W    = 24;
  localparam int GTIME_W   = 48;
  localparam int FRAME_W   = 32;
  localparam int FPS_W     = 24;
  localparam int SUM_W     = STEP_W + PTR_W;
  localparam int NUM_W     = STEP_W + PTR_W + 8;
  localparam int ITER_W    = $clog2(NUM_W + 1);
  localparam int PADDR_W   = 3;
  localparam int DATA_W    = 32;

  localparam logic [0:0] REG_MAX_STEP      = 1'b0;
  localparam logic [0:0] REG_TICKS_PER_SEC = 1'b1;

  localparam logic [STEP_W-1:0] MAX_STEP_RESET = 24'd60000;
  localparam logic [STEP_W-1:0] TPS_RESET      = 24'd1000000;

  typedef struct packed {
    logic [STEP_W-1:0] max_step_ticks;
    logic [STEP_W-1:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/frm_if.sv
// Valid/ready channel interfaces for frame inputs and rate results.
// Depends on frm_pkg.
interface frm_in_if;
  import frm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_ticks;
  modport source (output valid, output elapsed_ticks, input ready);
  modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface frm_out_if;
  import frm_pkg::*;
  logic               valid;
  logic               ready;
  logic [STEP_W-1:0]  step_ticks;
  logic [GTIME_W-1:0] global_ticks;
  logic [FRAME_W-1:0] frame_count;
  logic [FPS_W-1:0]   fps_q8;
  modport source (output valid, output step_ticks, output global_ticks,
                  output frame_count, output fps_q8, input ready);
  modport sink (input valid, input step_ticks, input global_ticks,
                input frame_count, input fps_q8, output ready);
endinterface

### rtl/frm_regs.sv
// APB-style configuration registers: step clamp and tick rate.
// Depends on frm_pkg.
module frm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frm_pkg::PADDR_W-1:0] paddr,
  input  logic [frm_pkg::DATA_W-1:0]  pwdata,
  output logic [frm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output frm_pkg::cfg_t               cfg
);
  import frm_pkg::*;

  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_step_ticks   <= MAX_STEP_RESET;
      cfg.ticks_per_second <= TPS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_STEP:      cfg.max_step_ticks   <= pwdata[STEP_W-1:0];
        REG_TICKS_PER_SEC: cfg.ticks_per_second <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_STEP:      prdata = DATA_W'(cfg.max_step_ticks);
      REG_TICKS_PER_SEC: prdata = DATA_W'(cfg.ticks_per_second);
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/frm_ring.sv
// Step history memory: one write and one registered read port.
// Depends on frm_pkg.
module frm_ring (
  input  logic                       clk,
  input  logic                       we,
  input  logic [frm_pkg::PTR_W-1:0]  waddr,
  input  logic [frm_pkg::STEP_W-1:0] wdata,
  input  logic                       re,
  input  logic [frm_pkg::PTR_W-1:0]  raddr,
  output logic [frm_pkg::STEP_W-1:0] rdata
);
  import frm_pkg::*;

  logic [STEP_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/frm_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, saturating
// the quotient to the rate width. Depends on frm_pkg.
module frm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [frm_pkg::NUM_W-1:0]  dividend,
  input  logic [frm_pkg::SUM_W-1:0]  divisor,
  output frm_pkg::div_status_t       status,
  output logic [frm_pkg::FPS_W-1:0]  quotient
);
  import frm_pkg::*;

  logic [NUM_W-1:0]  quo;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dvs;
  logic [ITER_W-1:0] count;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
      end else if (status.busy && count == ITER_W'(NUM_W - 1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      count <= '0;
    end else if (status.busy) begin
      quo   <= {quo[NUM_W-2:0], ge};
      rem   <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      count <= count + 1'b1;
    end
  end

  // zero divisor yields an all-ones quotient, which saturates
  assign quotient = (|quo[NUM_W-1:FPS_W]) ? '1 : quo[FPS_W-1:0];

endmodule

### rtl/frame_rate_meter_top.sv
// Frame rate meter top level: sequencer, running totals and step window.
// Depends on frm_pkg, frm_if, frm_regs, frm_ring and frm_div.
//
// Usage:
//   frames  : one transfer per frame carrying elapsed_ticks.
//   results : one transfer per frame with the clamped step, the global
//             time, the frame count and the windowed rate in 1/256 fps.
//   APB     : max_step_ticks at 0x0, ticks_per_second at 0x4; write only
//             while the block is idle.
// Timing: a frame is taken when the sequencer is idle. The old window entry is
// read as the frame is accepted and the totals update in the cycle after; then
// the divider produces one quotient bit per cycle. The result is registered
// once the division is done and the result register is free, and the next
// frame is taken only after that load, so frames are handled one at a time.
// A waiting result does not block the next frame's division; only its
// final load waits for the result register to drain.
// Reset: totals, frame count, window sum and pointer clear; the window
// reads as empty until it has been filled once. Registers take reset values.
module frame_rate_meter_top (
  input  logic                        clk,
  input  logic                        rst,
  frm_in_if.sink                      frames,
  frm_out_if.source                   results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frm_pkg::PADDR_W-1:0] paddr,
  input  logic [frm_pkg::DATA_W-1:0]  pwdata,
  output logic [frm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import frm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_START  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t             state;
  cfg_t               cfg;
  div_status_t        div_status;
  logic [FPS_W-1:0]   div_quotient;
  logic [NUM_W-1:0]   dividend;
  logic [STEP_W-1:0]  ring_rdata;
  logic [STEP_W-1:0]  old_step;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic [STEP_W-1:0]  limit;
  logic [PTR_W-1:0]   ring_pointer;
  logic               ring_full;
  logic [SUM_W-1:0]   window_sum;
  logic [GTIME_W-1:0] time_total;
  logic [FRAME_W-1:0] frames_seen;
  logic               in_xfer;
  logic               out_load;

  frm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frm_ring u_ring (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (ring_pointer),
    .wdata (step),
    .re    (in_xfer),
    .raddr (ring_pointer),
    .rdata (ring_rdata)
  );

  assign dividend = (NUM_W'(cfg.ticks_per_second) * NUM_W'(WINDOW)) << 8;

  frm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (dividend),
    .divisor  (window_sum),
    .status   (div_status),
    .quotient (div_quotient)
  );

  assign frames.ready = (state == S_IDLE);
  assign in_xfer      = frames.valid & frames.ready;
  assign out_load     = (state == S_FINISH) & (~results.valid | results.ready);
  assign old_step     = ring_full ? ring_rdata : '0;

  always_comb begin
    limit = (cfg.max_step_ticks == '0) ? STEP_W'(1) : cfg.max_step_ticks;
    if (frames.elapsed_ticks == '0) begin
      step_next = STEP_W'(1);
    end else if (frames.elapsed_ticks > ELAPSED_W'(limit)) begin
      step_next = limit;
    end else begin
      step_next = frames.elapsed_ticks[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_pointer  <= '0;
      ring_full     <= 1'b0;
      window_sum    <= '0;
      time_total    <= '0;
      frames_seen   <= '0;
      results.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          window_sum  <= window_sum - SUM_W'(old_step) + SUM_W'(step);
          time_total  <= time_total + GTIME_W'(step);
          frames_seen <= frames_seen + 1'b1;
          if (ring_pointer == PTR_W'(WINDOW - 1)) begin
            ring_pointer <= '0;
            ring_full    <= 1'b1;
          end else begin
            ring_pointer <= ring_pointer + 1'b1;
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      step <= step_next;
    end
    if (out_load) begin
      results.step_ticks   <= step;
      results.global_ticks <= time_total;
      results.frame_count  <= frames_seen;
      results.fps_q8       <= div_quotient;
    end
  end

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_READ)
    else $error("accepted frame did not start window read");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_START |=> div_status.busy)
    else $error("divider not busy after start");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_load |=> results.step_ticks != '0)
    else $error("zero step in result");

endmodule
